/* rtl/usvg_pkg.sv */
// shared constants, types and tables of the uv sphere vertex generator
`timescale 1ns / 1ps

package usvg_pkg;

    localparam int MAX_GRID  = 256;
    localparam int CNT_W     = 9;
    localparam int RAD_W     = 16;
    localparam int POS_W     = 17;
    localparam int NRM_W     = 16;
    localparam int TEX_W     = 17;
    localparam int VN_W      = 17;
    localparam int CFG_IDX_W = 2;

    // divider: 25-bit numerator, 17 quotient bits, one bit per stage
    localparam int DIV_N_W   = 25;
    localparam int DIV_Q_W   = 17;
    localparam int DIV_LAT   = DIV_Q_W;

    // sine/cosine unit
    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;
    localparam int SC_LAT    = 2 + 3 * COS_STEPS + 2;

    // input register, divider, sincos, four product and rounding stages
    localparam int PIPE_LAT  = 1 + DIV_LAT + SC_LAT + 4;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // taylor denominators and floor(2^32 / k) reciprocals
    localparam logic [7:0] SIN_DEN [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DEN [COS_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
        32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
    };
    localparam logic [31:0] COS_RCP [COS_STEPS] = '{
        32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941,
        32'd2147483648
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_RINGS  = 2'd1,
        REG_SLICES = 2'd2
    } cfg_reg_e;

    typedef logic [1:0] quad_t;

    typedef struct packed {
        logic [VN_W-1:0] vertex_number;
        logic [VN_W-1:0] next_row_number;
        logic            opens_quad;
    } index_t;

    typedef struct packed {
        index_t           idx;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } side_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        side_t                   side;
    } vertex_t;

endpackage

/* rtl/uv_sphere_vertex_generator.sv */
// top level of the uv sphere vertex generator
`timescale 1ns / 1ps

// Takes one grid point (ring, slice) per beat and returns its UV-sphere vertex: texture
// coordinates u = slice/slices and v = ring/rings (Q1.16, rounded half up), the position
// radius*(sin phi cos theta, cos phi, sin phi sin theta) in Q8.8 with phi = v*pi and
// theta = u*2pi, the unit normal in Q1.14 (also at radius zero), the linear vertex index,
// the index one ring on, and a flag for points that open a quad. A new point is taken
// every clock while s_tready is high. Most of the pipe depth is in the 17-stage
// bit-per-stage divider for u and v and in the 22-stage sine/cosine pipe,
// whose six nested taylor steps each take a multiply, a reciprocal multiply and a
// correction stage. A two-entry output buffer lets the input keep flowing while one
// result waits; s_tready drops only when both entries are full and m_tready is low.
// Counts of zero act as one, counts above 256 act as 256, and indices above their
// count saturate to it. Config writes are meant for idle periods only.
module uv_sphere_vertex_generator import usvg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // ring_index, slice_index, zero pad
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
    // vertex_number, next_row_number, zero pad
    output logic [167:0]         m_tdata,
    output logic                 m_tuser,   // opens_quad
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAD_W-1:0]     cfg_data
);

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        if (c == '0)
        begin
            return CNT_W'(1);
        end
        if (c > CNT_W'(MAX_GRID))
        begin
            return CNT_W'(MAX_GRID);
        end
        return c;
    endfunction

    // round v / 2^n half away from zero
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (n - 1))) >> n;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    // config registers
    logic [RAD_W-1:0] radius_reg;
    logic [CNT_W-1:0] rings_raw_reg;
    logic [CNT_W-1:0] slices_raw_reg;
    logic [CNT_W-1:0] rings;
    logic [CNT_W-1:0] slices;

    // pipeline control
    logic                adv;
    logic [PIPE_LAT-1:0] vld_reg;

    // input stage
    logic [CNT_W-1:0] ring_in;
    logic [CNT_W-1:0] slice_in;
    logic [CNT_W-1:0] ring_reg;
    logic [CNT_W-1:0] slice_reg;
    index_t           idx_next;
    logic [DIV_N_W-1:0] num_u;
    logic [DIV_N_W-1:0] num_v;

    // side data delay lines
    index_t idx_line_reg  [DIV_LAT];
    side_t  side_line_reg [SC_LAT+3];

    // divider and sincos results
    logic [DIV_Q_W-1:0] tex_u;
    logic [DIV_Q_W-1:0] tex_v;
    logic signed [31:0] sin_t;
    logic signed [31:0] cos_t;
    logic signed [31:0] sin_p;
    logic signed [31:0] cos_p;

    // product and rounding stages
    logic signed [63:0] mx_reg;
    logic signed [63:0] mz_reg;
    logic signed [31:0] cp1_reg;
    logic signed [31:0] tx_reg;
    logic signed [31:0] tz_reg;
    logic signed [31:0] cp2_reg;
    logic signed [48:0] px_reg;
    logic signed [48:0] py_reg;
    logic signed [48:0] pz_reg;
    logic signed [NRM_W-1:0] nx_reg;
    logic signed [NRM_W-1:0] ny_reg;
    logic signed [NRM_W-1:0] nz_reg;
    logic signed [POS_W:0]   rad_s;
    vertex_t vert_reg;

    // output buffer
    vertex_t buf_reg [2];
    logic [1:0] cnt_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    logic       pop;
    vertex_t    head;

    assign rings     = clamp_count(rings_raw_reg);
    assign slices    = clamp_count(slices_raw_reg);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= RAD_W'(256);
            rings_raw_reg  <= CNT_W'(16);
            slices_raw_reg <= CNT_W'(32);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_RADIUS: radius_reg     <= cfg_data;
                REG_RINGS:  rings_raw_reg  <= cfg_data[CNT_W-1:0];
                REG_SLICES: slices_raw_reg <= cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // whole pipe moves unless both buffer entries are held
    assign adv      = (cnt_reg != 2'd2) || m_tready;
    assign s_tready = adv;
    assign push     = adv && vld_reg[PIPE_LAT-1];
    assign pop      = (cnt_reg != 2'd0) && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    // saturate indices to the counts
    always_comb
    begin
        ring_in  = (s_tdata[8:0] > rings) ? rings : s_tdata[8:0];
        slice_in = (s_tdata[17:9] > slices) ? slices : s_tdata[17:9];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ring_reg  <= ring_in;
            slice_reg <= slice_in;
        end
    end

    // linear indices, numerators with half-divisor rounding
    always_comb
    begin
        idx_next.vertex_number   = VN_W'(ring_reg) * (VN_W'(slices) + VN_W'(1))
                                   + VN_W'(slice_reg);
        idx_next.next_row_number = idx_next.vertex_number + VN_W'(slices) + VN_W'(1);
        idx_next.opens_quad      = (ring_reg < rings) && (slice_reg < slices);
        num_u = {slice_reg, 16'b0} + DIV_N_W'(slices[CNT_W-1:1]);
        num_v = {ring_reg, 16'b0} + DIV_N_W'(rings[CNT_W-1:1]);
    end

    usvg_div u_div_u
    (
        .clk (clk),
        .en  (adv),
        .num (num_u),
        .den (slices),
        .quo (tex_u)
    );

    usvg_div u_div_v
    (
        .clk (clk),
        .en  (adv),
        .num (num_v),
        .den (rings),
        .quo (tex_v)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_line_reg[0] <= idx_next;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                idx_line_reg[k] <= idx_line_reg[k-1];
            end
            side_line_reg[0] <= '{idx: idx_line_reg[DIV_LAT-1], tex_u: tex_u, tex_v: tex_v};
            for (int k = 1; k < SC_LAT + 3; k++)
            begin
                side_line_reg[k] <= side_line_reg[k-1];
            end
        end
    end

    // theta = u turns, phi = v half turns, both as q0.32
    usvg_sincos u_sc_theta
    (
        .clk   (clk),
        .en    (adv),
        .angle ({tex_u[15:0], 16'b0}),
        .sn    (sin_t),
        .cs    (cos_t)
    );

    usvg_sincos u_sc_phi
    (
        .clk   (clk),
        .en    (adv),
        .angle ({tex_v, 15'b0}),
        .sn    (sin_p),
        .cs    (cos_p)
    );

    assign rad_s = $signed({2'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // sin phi times cos / sin theta
            mx_reg  <= sin_p * cos_t;
            mz_reg  <= sin_p * sin_t;
            cp1_reg <= cos_p;
            // back to q30
            tx_reg  <= 32'(rnd(mx_reg, 30));
            tz_reg  <= 32'(rnd(mz_reg, 30));
            cp2_reg <= cp1_reg;
            // scale by radius, normals to q14
            px_reg  <= rad_s * tx_reg;
            py_reg  <= rad_s * cp2_reg;
            pz_reg  <= rad_s * tz_reg;
            nx_reg  <= NRM_W'(rnd(64'(tx_reg), 16));
            ny_reg  <= NRM_W'(rnd(64'(cp2_reg), 16));
            nz_reg  <= NRM_W'(rnd(64'(tz_reg), 16));
            // positions to q8.8
            vert_reg.pos_x    <= POS_W'(rnd(64'(px_reg), 30));
            vert_reg.pos_y    <= POS_W'(rnd(64'(py_reg), 30));
            vert_reg.pos_z    <= POS_W'(rnd(64'(pz_reg), 30));
            vert_reg.normal_x <= nx_reg;
            vert_reg.normal_y <= ny_reg;
            vert_reg.normal_z <= nz_reg;
            vert_reg.side     <= side_line_reg[SC_LAT+2];
        end
    end

    // two-entry output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= vert_reg;
        end
    end

    assign head     = buf_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = head.side.idx.opens_quad;
    assign m_tdata  = {1'b0,
                       head.side.idx.next_row_number,
                       head.side.idx.vertex_number,
                       head.side.tex_v,
                       head.side.tex_u,
                       head.normal_z,
                       head.normal_y,
                       head.normal_x,
                       head.pos_z,
                       head.pos_y,
                       head.pos_x};

endmodule

/* rtl/usvg_div.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module usvg_div import usvg_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [DIV_N_W-1:0] num,
    input  logic [CNT_W-1:0]   den,
    output logic [DIV_Q_W-1:0] quo
);

    logic [CNT_W-1:0]   rem_reg [DIV_LAT-1];
    logic [DIV_Q_W-1:0] low_reg [DIV_LAT-1];
    logic [DIV_Q_W-1:0] q_reg   [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_bit
        logic [CNT_W-1:0]   rem_in;
        logic [DIV_Q_W-1:0] low_in;
        logic [DIV_Q_W-1:0] q_in;
        logic [CNT_W:0]     trial;
        logic               ge;
        logic [CNT_W-1:0]   rem_next;
        logic [DIV_Q_W-1:0] q_next;

        if (k == 0)
        begin : g_first
            // numerator top bits are always below the divisor
            assign rem_in = {1'b0, num[DIV_N_W-1:DIV_Q_W]};
            assign low_in = num[DIV_Q_W-1:0];
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_in, low_in[DIV_Q_W-1-k]};
            ge       = (trial >= {1'b0, den});
            rem_next = ge ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
            q_next   = q_in;
            q_next[DIV_Q_W-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= q_next;
            end
        end

        if (k < DIV_LAT - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= low_in;
                end
            end
        end
    end

    assign quo = q_reg[DIV_LAT-1];

endmodule

/* rtl/usvg_sincos.sv */
// pipelined sine and cosine of an angle in turns, nested taylor forms in q2.30
`timescale 1ns / 1ps

module usvg_sincos import usvg_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        angle,
    output logic signed [31:0] sn,
    output logic signed [31:0] cs
);

    function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [30:0] t);
        logic [62:0] pr;
        pr = {31'b0, a} * {32'b0, t};
        return pr[61:30];
    endfunction

    function automatic logic [31:0] mul_rcp(input logic [31:0] q, input logic [31:0] m);
        logic [63:0] pr;
        pr = {32'b0, q} * {32'b0, m};
        return pr[63:32];
    endfunction

    // quotient estimate is low by at most one, then t = 1 - p clamped at zero
    function automatic logic [30:0] nest_t(input logic [31:0] q, input logic [31:0] e,
                                           input logic [7:0] k);
        logic [39:0] kq;
        logic [31:0] r;
        logic [31:0] p;
        kq = {8'b0, e} * {32'b0, k};
        r  = q - kq[31:0];
        p  = (r >= {24'b0, k}) ? e + 32'd1 : e;
        return (p > {1'b0, ONE_Q30}) ? '0 : 31'({1'b0, ONE_Q30} - p);
    endfunction

    logic [30:0] x1_reg;
    quad_t       q1_reg;
    logic [30:0] xb   [COS_STEPS+1];
    logic [31:0] x2b  [COS_STEPS];
    quad_t       qb   [COS_STEPS+1];
    logic [30:0] ts_b [COS_STEPS];
    logic [30:0] tc_b [COS_STEPS];
    logic [30:0] s_reg;
    logic [30:0] c_reg;
    quad_t       qf_reg;
    logic signed [31:0] sn_reg;
    logic signed [31:0] cs_reg;

    logic [61:0] ang_prod;
    logic [61:0] sq_prod;
    logic [61:0] sin_prod;
    logic [31:0] s_full;

    always_comb
    begin
        ang_prod = {32'b0, angle[29:0]} * {30'b0, PI_Q30};
        sq_prod  = {31'b0, x1_reg} * {31'b0, x1_reg};
        sin_prod = {31'b0, xb[COS_STEPS]} * {31'b0, ts_b[COS_STEPS-1]};
        s_full   = sin_prod[61:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= ang_prod[61:31];
            q1_reg <= angle[31:30];
            xb[0]  <= x1_reg;
            x2b[0] <= sq_prod[61:30];
            qb[0]  <= q1_reg;
        end
    end

    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_step
        logic [30:0] ts_in;
        logic [30:0] tc_in;
        logic [30:0] a_x_reg;
        quad_t       a_q_reg;
        logic [31:0] a_qc_reg;
        logic [30:0] b_x_reg;
        quad_t       b_q_reg;
        logic [31:0] b_qc_reg;
        logic [31:0] b_ec_reg;

        if (i == 0)
        begin : g_init
            assign ts_in = ONE_Q30;
            assign tc_in = ONE_Q30;
        end
        else
        begin : g_chain
            assign ts_in = ts_b[i-1];
            assign tc_in = tc_b[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_x_reg   <= xb[i];
                a_q_reg   <= qb[i];
                a_qc_reg  <= mul_q30(x2b[i], tc_in);
                b_x_reg   <= a_x_reg;
                b_q_reg   <= a_q_reg;
                b_qc_reg  <= a_qc_reg;
                b_ec_reg  <= mul_rcp(a_qc_reg, COS_RCP[i]);
                xb[i+1]   <= b_x_reg;
                qb[i+1]   <= b_q_reg;
                tc_b[i]   <= nest_t(b_qc_reg, b_ec_reg, COS_DEN[i]);
            end
        end

        if (i < COS_STEPS - 1)
        begin : g_x2
            logic [31:0] a_x2_reg;
            logic [31:0] b_x2_reg;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_x2_reg <= x2b[i];
                    b_x2_reg <= a_x2_reg;
                    x2b[i+1] <= b_x2_reg;
                end
            end
        end

        if (i < SIN_STEPS)
        begin : g_sin
            logic [31:0] a_qs_reg;
            logic [31:0] b_qs_reg;
            logic [31:0] b_es_reg;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_qs_reg <= mul_q30(x2b[i], ts_in);
                    b_qs_reg <= a_qs_reg;
                    b_es_reg <= mul_rcp(a_qs_reg, SIN_RCP[i]);
                    ts_b[i]  <= nest_t(b_qs_reg, b_es_reg, SIN_DEN[i]);
                end
            end
        end
        else
        begin : g_sin_hold
            logic [30:0] a_ts_reg;
            logic [30:0] b_ts_reg;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_ts_reg <= ts_in;
                    b_ts_reg <= a_ts_reg;
                    ts_b[i]  <= b_ts_reg;
                end
            end
        end
    end

    // sin = x * poly, clamped to one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg  <= (s_full > {1'b0, ONE_Q30}) ? ONE_Q30 : s_full[30:0];
            c_reg  <= tc_b[COS_STEPS-1];
            qf_reg <= qb[COS_STEPS];
        end
    end

    // quadrant symmetry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (qf_reg)
                2'd0:
                begin
                    sn_reg <= $signed({1'b0, s_reg});
                    cs_reg <= $signed({1'b0, c_reg});
                end
                2'd1:
                begin
                    sn_reg <= $signed({1'b0, c_reg});
                    cs_reg <= -$signed({1'b0, s_reg});
                end
                2'd2:
                begin
                    sn_reg <= -$signed({1'b0, s_reg});
                    cs_reg <= -$signed({1'b0, c_reg});
                end
                default:
                begin
                    sn_reg <= -$signed({1'b0, c_reg});
                    cs_reg <= $signed({1'b0, s_reg});
                end
            endcase
        end
    end

    assign sn = sn_reg;
    assign cs = cs_reg;

endmodule

/* rtl/usvg_checker.sv */
// port-level checks of the uv sphere vertex generator and their bind
`timescale 1ns / 1ps

module usvg_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [23:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata,
    input logic         m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [1:0]   cfg_index,
    input logic [15:0]  cfg_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // input backpressure only while a result is waiting and not taken
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // a quad opener never sits on the last row or column
    a_quad_tex: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[115] && !m_tdata[132])
        else $error("quad flag on a seam point");

    // next ring index lies beyond this vertex
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[166:150] > m_tdata[149:133])
        else $error("next row index not above vertex index");

endmodule

bind uv_sphere_vertex_generator usvg_checker u_usvg_checker (.*);
